// ----- rtl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types for the LRU page replacement unit
// Scan token that walks the frame cells and the update command that the
// controller broadcasts to all cells at the end of a scan.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Field widths sized for the largest supported frame row and page number
    localparam int IDX_W_MAX  = 6;
    localparam int RANK_W_MAX = 6;
    localparam int PAGE_W_MAX = 32;

    localparam int          FAULT_W   = 16;
    localparam logic [15:0] FAULT_MAX = 16'hFFFF;

    // Running search result, handed from cell to cell
    typedef struct packed {
        logic                  hit;
        logic [IDX_W_MAX-1:0]  hit_idx;
        logic [RANK_W_MAX-1:0] hit_rank;
        logic                  emp;
        logic [IDX_W_MAX-1:0]  emp_idx;
        logic                  best_set;
        logic [IDX_W_MAX-1:0]  best_idx;
        logic [RANK_W_MAX-1:0] best_rank;
        logic [PAGE_W_MAX-1:0] best_page;
    } t_scan_tok;

    // Recency and fill update, applied by every cell in the same cycle
    typedef struct packed {
        logic                  apply;
        logic [IDX_W_MAX-1:0]  slot;
        logic                  age_all;
        logic [RANK_W_MAX-1:0] limit;
        logic                  fill;
    } t_cell_upd;

endpackage

// ----- rtl/lpr_cell.sv -----
// ----------------------------------------------------------------------------
// lpr_cell: one page frame of the replacement row
// Holds page, valid and recency rank; folds its frame into the scan token
// and registers the token toward the next cell.
// ----------------------------------------------------------------------------
module lpr_cell #(
    parameter int  MAX_FRAMES = 8,
    parameter int  PAGE_BITS  = 8,
    parameter int  IDX        = 0,
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpr_pkg::t_scan_tok    i_tok,
    input  logic                  i_tok_vld,
    output lpr_pkg::t_scan_tok    o_tok,
    output logic                  o_tok_vld,
    input  logic [CNT_W-1:0]      i_n_eff,
    input  logic [PAGE_BITS-1:0]  i_ref_page,
    input  lpr_pkg::t_cell_upd    i_upd
);
    import lpr_pkg::*;

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_W-1:0]    r_rank;
    logic                 r_tok_vld;
    t_scan_tok            r_tok;
    t_scan_tok            n_tok;
    logic                 active;
    logic                 is_slot;
    logic                 age;

    assign active  = CNT_W'(IDX) < i_n_eff;
    assign is_slot = i_upd.slot == IDX_W_MAX'(IDX);
    assign age     = r_valid
                   && (i_upd.age_all || RANK_W_MAX'(r_rank) < i_upd.limit)
                   && (r_rank < RANK_W'(MAX_FRAMES - 1));

    always_comb begin
        n_tok = i_tok;
        if (active && r_valid && (r_page == i_ref_page) && !i_tok.hit) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = IDX_W_MAX'(IDX);
            n_tok.hit_rank = RANK_W_MAX'(r_rank);
        end
        if (active && !r_valid && !i_tok.emp) begin
            n_tok.emp     = 1'b1;
            n_tok.emp_idx = IDX_W_MAX'(IDX);
        end
        if (active && (!i_tok.best_set || RANK_W_MAX'(r_rank) > i_tok.best_rank)) begin
            n_tok.best_set  = 1'b1;
            n_tok.best_idx  = IDX_W_MAX'(IDX);
            n_tok.best_rank = RANK_W_MAX'(r_rank);
            n_tok.best_page = PAGE_W_MAX'(r_page);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_rank    <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (i_upd.apply) begin
                if (is_slot) begin
                    r_rank <= '0;
                    if (i_upd.fill) begin
                        r_valid <= 1'b1;
                    end
                end else if (age) begin
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_vld) begin
            r_tok <= n_tok;
        end
        if (i_upd.apply && is_slot && i_upd.fill) begin
            r_page <= i_ref_page;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_vld = r_tok_vld;

endmodule

// ----- rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page frame replacement unit
// The unit takes one reference at a time: the scan token walks the row of
// frame cells one cell per cycle, then comes the update cycle, then the
// result cycle, in which busy is low and the next start beat can land.
// Reset: synchronous, active low; empties all frames, clears ranks and the
// fault total, sets the frame count register to 8. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [PAGE_BITS-1:0] i_page_id,
    output logic                 o_done,
    output logic                 o_fault,
    output logic [2:0]           o_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [15:0]          o_fault_total
);
    import lpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    // Control and configuration
    logic [3:0]           r_frames;
    logic                 r_busy;
    logic                 r_inject;
    logic [PAGE_BITS-1:0] r_page;
    logic                 accept;
    logic [CNT_W-1:0]     eff_cnt;

    // Result registers
    logic                 r_done;
    logic                 r_fault;
    logic [2:0]           r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic [FAULT_W-1:0]   r_fault_cnt;
    logic [FAULT_W-1:0]   n_fault_cnt;

    // Cell row: token k enters cell k, token k+1 leaves it
    t_scan_tok tok_chain [MAX_FRAMES+1];
    logic      vld_chain [MAX_FRAMES+1];
    t_scan_tok last_tok;
    logic      scan_done;
    t_cell_upd upd;
    logic [IDX_W_MAX-1:0] sel_slot;

    assign accept = i_start && !r_busy;

    // Clamp the configured frame count into 1 .. MAX_FRAMES
    always_comb begin
        if (r_frames == 4'd0) begin
            eff_cnt = CNT_W'(1);
        end else if (int'(r_frames) > MAX_FRAMES) begin
            eff_cnt = CNT_W'(MAX_FRAMES);
        end else begin
            eff_cnt = CNT_W'(r_frames);
        end
    end

    // Fresh token: nothing found yet
    assign tok_chain[0] = '0;
    assign vld_chain[0] = r_inject;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lpr_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok_chain[g]),
            .i_tok_vld  (vld_chain[g]),
            .o_tok      (tok_chain[g+1]),
            .o_tok_vld  (vld_chain[g+1]),
            .i_n_eff    (eff_cnt),
            .i_ref_page (r_page),
            .i_upd      (upd)
        );
    end

    assign last_tok  = tok_chain[MAX_FRAMES];
    assign scan_done = vld_chain[MAX_FRAMES];

    // Decide when the token leaves the last cell: hit first, then the
    // lowest empty frame, else evict the oldest active frame.
    always_comb begin
        upd       = '0;
        upd.apply = scan_done;
        if (last_tok.hit) begin
            sel_slot  = last_tok.hit_idx;
            upd.limit = last_tok.hit_rank;
        end else if (last_tok.emp) begin
            sel_slot    = last_tok.emp_idx;
            upd.age_all = 1'b1;
            upd.fill    = 1'b1;
        end else begin
            sel_slot  = last_tok.best_idx;
            upd.limit = last_tok.best_rank;
            upd.fill  = 1'b1;
        end
        upd.slot = sel_slot;
    end

    // Saturating fault total
    always_comb begin
        n_fault_cnt = r_fault_cnt;
        if (!last_tok.hit && r_fault_cnt != FAULT_MAX) begin
            n_fault_cnt = r_fault_cnt + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= 4'd8;
            r_busy      <= 1'b0;
            r_inject    <= 1'b0;
            r_done      <= 1'b0;
            r_fault_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
            r_inject <= accept;
            r_done   <= scan_done;
            // Hold busy from the start beat until the update cycle
            if (accept) begin
                r_busy <= 1'b1;
            end else if (scan_done) begin
                r_busy <= 1'b0;
            end
            if (scan_done) begin
                r_fault_cnt <= n_fault_cnt;
            end
        end
    end

    // Payload: capture the reference and the result beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page_id;
        end
        if (scan_done) begin
            r_fault    <= !last_tok.hit;
            r_slot     <= sel_slot[2:0];
            r_ev_valid <= !last_tok.hit && !last_tok.emp;
            r_ev_page  <= (!last_tok.hit && !last_tok.emp)
                        ? last_tok.best_page[PAGE_BITS-1:0] : '0;
        end
    end

    assign o_busy          = r_busy;
    assign o_done          = r_done;
    assign o_fault         = r_fault;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_cnt;

    // A scan token only reaches the row end while an item is in flight
    a_scan_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> r_busy)
        else $error("scan token left the row with no item in flight");

    // A result beat follows the update cycle, which released busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("result beat while still busy");

    // The fault total moves only on a result beat
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> $stable(r_fault_cnt))
        else $error("fault total changed without a result");

    // A hit leaves the fault total alone and never evicts
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_fault) |-> (!r_ev_valid && r_fault_cnt == $past(r_fault_cnt)))
        else $error("hit changed the fault total or evicted a page");

endmodule
